/* sv/min_line_hull_container_defines.svh */
// assertion macros for the line hull container
`ifndef MIN_LINE_HULL_CONTAINER_DEFINES_SVH
`define MIN_LINE_HULL_CONTAINER_DEFINES_SVH
`ifndef SYNTHESIS
`define MLH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlh check failed");
`define MLH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlh check failed");
`else
`define MLH_ASSERT_NOW(lbl, ante, cons)
`define MLH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/mlh_pkg.sv */
// shared types and constants of the line hull container
`timescale 1ns / 1ps
package mlh_pkg;
  localparam int HULL_DEPTH = 1024;
  localparam int ADDR_W = $clog2(HULL_DEPTH);
  localparam int CNT_W = $clog2(HULL_DEPTH + 1);
  localparam int SLOPE_W = 24;
  localparam int ICPT_W = 48;
  localparam int NUM_W = 49;
  localparam int X_W = 24;
  localparam int VALUE_W = 49;
  localparam int COUNT_W = 11;
  localparam int PROD_W = 48;
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SLOPE = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [ICPT_W-1:0] icpt;
    logic [NUM_W-1:0] num;
    logic [SLOPE_W-1:0] den;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_RD,
    S_Q_MUL,
    S_Q_CMP,
    S_Q_VMUL,
    S_Q_VADD,
    S_A_TOP,
    S_A_UND,
    S_A_GO,
    S_A_CMP,
    S_A_PUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic greater;
  } xcmp_t;
endpackage

/* sv/mlh_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module mlh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* sv/mlh_xmul.sv */
// iterative exact compare of n1*d2 against n2*d1
`timescale 1ns / 1ps
module mlh_xmul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mlh_pkg::NUM_W-1:0]       n1,
  input  logic [mlh_pkg::SLOPE_W-1:0]     d1,
  input  logic [mlh_pkg::NUM_W-1:0]       n2,
  input  logic [mlh_pkg::SLOPE_W-1:0]     d2,
  output mlh_pkg::xcmp_t                  res
);
  localparam int HALF = 25;
  localparam int PW = 2 * HALF + 1;
  localparam int ACC_W = 3 * HALF + 1;

  logic [mlh_pkg::NUM_W-1:0] n1_r, n2_r;
  logic [mlh_pkg::SLOPE_W-1:0] d1_r, d2_r;
  logic [2:0] k_r;
  logic [1:0] pk_r;
  logic busy_r, pvalid_r, done_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [2*HALF-1:0] nsel;
  logic signed [HALF:0] a_op;
  logic signed [HALF:0] b_op;
  logic signed [ACC_W-1:0] term;

  always_comb begin
    nsel = k_r[1] ? {n2_r[mlh_pkg::NUM_W-1], n2_r} : {n1_r[mlh_pkg::NUM_W-1], n1_r};
    // low half unsigned, high half signed
    a_op = k_r[0] ? $signed({nsel[2*HALF-1], nsel[2*HALF-1:HALF]})
                  : $signed({1'b0, nsel[HALF-1:0]});
    b_op = k_r[1] ? $signed({2'b00, d1_r}) : $signed({2'b00, d2_r});
    term = pk_r[0] ? (ACC_W'(prod_r) <<< HALF) : ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n1_r <= n1;
      n2_r <= n2;
      d1_r <= d1;
      d2_r <= d2;
    end
    if (busy_r && !k_r[2]) begin
      prod_r <= PW'(a_op * b_op);
      pk_r <= k_r[1:0];
    end
    if (start) begin
      acc_r <= '0;
    end else if (pvalid_r) begin
      acc_r <= pk_r[1] ? acc_r - term : acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pvalid_r <= 1'b0;
      done_r <= 1'b0;
      k_r <= '0;
    end else begin
      done_r <= pvalid_r && (pk_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        k_r <= '0;
        pvalid_r <= 1'b0;
      end else begin
        pvalid_r <= busy_r && !k_r[2];
        if (busy_r && !k_r[2]) begin
          k_r <= k_r + 3'd1;
        end
        if (pvalid_r && (pk_r == 2'd3)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.greater = (acc_r > 0);
endmodule

/* sv/min_line_hull_container.sv */
// top level: convex hull line store with minimum queries
// query: a binary search over the lines, each step a ram read, a multiply and a compare
// add: one cross compare (read, start, iterative multiply) per popped line and one that
//   keeps the top, each made only while two or more lines are on the hull
// one request in work; the next is taken once its result is out; reset clears size and control
`timescale 1ns / 1ps
`include "min_line_hull_container_defines.svh"
module min_line_hull_container (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [23:0]                   in_line_slope,
  input  logic [47:0]                   in_line_intercept,
  input  logic [23:0]                   in_query_x,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [48:0]                   out_value,
  output logic [10:0]                   out_line_count
);
  localparam int AW = mlh_pkg::ADDR_W;
  localparam int CW = mlh_pkg::CNT_W;

  mlh_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hie_r, hie_nxt;
  logic [AW-1:0] mid_r, mid_nxt, pos_r, pos_nxt;
  logic kind_r;
  logic [mlh_pkg::SLOPE_W-1:0] slope_r;
  logic [mlh_pkg::ICPT_W-1:0] icpt_r;
  logic [mlh_pkg::X_W-1:0] x_r;
  mlh_pkg::line_t tline_r, tline_nxt, uline_r, uline_nxt;
  logic [mlh_pkg::PROD_W-1:0] prod_r, prod_nxt;
  mlh_pkg::status_t res_status_r, res_status_nxt;
  logic [mlh_pkg::VALUE_W-1:0] res_value_r, res_value_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  logic [mlh_pkg::VALUE_W-1:0] out_value_r;
  logic [CW-1:0] out_count_r;

  // memory port
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  mlh_pkg::line_t ram_wdata, ram_rdata;

  // cross compare unit
  logic xc_start;
  logic [mlh_pkg::NUM_W-1:0] xc_n1, xc_n2;
  logic [mlh_pkg::SLOPE_W-1:0] xc_d1, xc_d2;
  mlh_pkg::xcmp_t xc_res;

  logic in_take;
  logic [CW:0] mid_sum;
  logic [AW-1:0] mid_calc;
  logic num_le;
  logic [CW-1:0] top_dec;

  assign in_ready = (state_r == mlh_pkg::S_IDLE);
  assign in_take = in_valid && in_ready;

  mlh_ram #(
    .WIDTH(mlh_pkg::LINE_W),
    .DEPTH(mlh_pkg::HULL_DEPTH)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // intersections: top with under, new with under
  assign xc_n1 = {1'b0, tline_r.icpt} - {1'b0, uline_r.icpt};
  assign xc_d1 = uline_r.slope - tline_r.slope;
  assign xc_n2 = {1'b0, icpt_r} - {1'b0, uline_r.icpt};
  assign xc_d2 = uline_r.slope - slope_r;

  mlh_xmul u_xmul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(xc_start),
    .n1   (xc_n1),
    .d1   (xc_d1),
    .n2   (xc_n2),
    .d2   (xc_d2),
    .res  (xc_res)
  );

  // binary search midpoint over [lo, hie)
  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hie_nxt} - (CW+1)'(1);
  assign mid_calc = mid_sum[AW:1];
  // start of line at or below x: num <= x*den, signed
  assign num_le = $signed({ram_rdata.num[mlh_pkg::NUM_W-1], ram_rdata.num})
                  <= $signed({2'b00, prod_r});
  assign top_dec = top_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    size_nxt = size_r;
    top_nxt = top_r;
    lo_nxt = lo_r;
    hie_nxt = hie_r;
    mid_nxt = mid_r;
    pos_nxt = pos_r;
    tline_nxt = tline_r;
    uline_nxt = uline_r;
    prod_nxt = prod_r;
    res_status_nxt = res_status_r;
    res_value_nxt = res_value_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we = 1'b0;
    ram_waddr = top_r[AW-1:0];
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = mid_r;
    xc_start = 1'b0;

    case (state_r)
      mlh_pkg::S_IDLE: begin
        res_value_nxt = '0;
        res_status_nxt = mlh_pkg::ST_OK;
        if (in_take) begin
          if (in_req_type == mlh_pkg::REQ_QUERY) begin
            if (size_r == '0) begin
              res_status_nxt = mlh_pkg::ST_EMPTY;
              state_nxt = mlh_pkg::S_DONE;
            end else begin
              lo_nxt = '0;
              hie_nxt = size_r;
              pos_nxt = '0;
              mid_nxt = mid_calc;
              state_nxt = mlh_pkg::S_Q_RD;
            end
          end else begin
            top_nxt = size_r;
            if (size_r == '0) begin
              state_nxt = mlh_pkg::S_A_PUSH;
            end else begin
              // fetch the current top line
              ram_re = 1'b1;
              ram_raddr = AW'(size_r - CW'(1));
              state_nxt = mlh_pkg::S_A_TOP;
            end
          end
        end
      end
      mlh_pkg::S_Q_RD: begin
        ram_re = 1'b1;
        ram_raddr = mid_r;
        state_nxt = mlh_pkg::S_Q_MUL;
      end
      mlh_pkg::S_Q_MUL: begin
        prod_nxt = mlh_pkg::PROD_W'(x_r * ram_rdata.den);
        state_nxt = mlh_pkg::S_Q_CMP;
      end
      mlh_pkg::S_Q_CMP: begin
        if (num_le) begin
          pos_nxt = mid_r;
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hie_nxt = CW'(mid_r);
        end
        mid_nxt = mid_calc;
        if (lo_nxt < hie_nxt) begin
          state_nxt = mlh_pkg::S_Q_RD;
        end else begin
          ram_re = 1'b1;
          ram_raddr = pos_nxt;
          state_nxt = mlh_pkg::S_Q_VMUL;
        end
      end
      mlh_pkg::S_Q_VMUL: begin
        prod_nxt = mlh_pkg::PROD_W'(ram_rdata.slope * x_r);
        state_nxt = mlh_pkg::S_Q_VADD;
      end
      mlh_pkg::S_Q_VADD: begin
        res_value_nxt = {1'b0, prod_r} + {1'b0, ram_rdata.icpt};
        state_nxt = mlh_pkg::S_DONE;
      end
      mlh_pkg::S_A_TOP: begin
        tline_nxt = ram_rdata;
        if (slope_r >= ram_rdata.slope) begin
          res_status_nxt = mlh_pkg::ST_SLOPE;
          state_nxt = mlh_pkg::S_DONE;
        end else if (top_r >= CW'(2)) begin
          ram_re = 1'b1;
          ram_raddr = AW'(top_r - CW'(2));
          state_nxt = mlh_pkg::S_A_UND;
        end else begin
          state_nxt = mlh_pkg::S_A_PUSH;
        end
      end
      mlh_pkg::S_A_UND: begin
        uline_nxt = ram_rdata;
        state_nxt = mlh_pkg::S_A_GO;
      end
      mlh_pkg::S_A_GO: begin
        xc_start = 1'b1;
        state_nxt = mlh_pkg::S_A_CMP;
      end
      mlh_pkg::S_A_CMP: begin
        if (xc_res.done) begin
          if (xc_res.greater) begin
            // pop: the line under becomes the top
            top_nxt = top_dec;
            tline_nxt = uline_r;
            if (top_dec >= CW'(2)) begin
              ram_re = 1'b1;
              ram_raddr = AW'(top_dec - CW'(2));
              state_nxt = mlh_pkg::S_A_UND;
            end else begin
              state_nxt = mlh_pkg::S_A_PUSH;
            end
          end else begin
            state_nxt = mlh_pkg::S_A_PUSH;
          end
        end
      end
      mlh_pkg::S_A_PUSH: begin
        if (top_r >= CW'(mlh_pkg::HULL_DEPTH)) begin
          res_status_nxt = mlh_pkg::ST_FULL;
        end else begin
          ram_we = 1'b1;
          ram_waddr = top_r[AW-1:0];
          ram_wdata.slope = slope_r;
          ram_wdata.icpt = icpt_r;
          if (top_r == '0) begin
            // first line starts at -1/1
            ram_wdata.num = '1;
            ram_wdata.den = mlh_pkg::SLOPE_W'(1);
          end else begin
            ram_wdata.num = {1'b0, icpt_r} - {1'b0, tline_r.icpt};
            ram_wdata.den = tline_r.slope - slope_r;
          end
          size_nxt = top_r + CW'(1);
        end
        state_nxt = mlh_pkg::S_DONE;
      end
      mlh_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = mlh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mlh_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlh_pkg::S_IDLE;
      size_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r <= in_req_type;
      slope_r <= in_line_slope;
      icpt_r <= in_line_intercept;
      x_r <= in_query_x;
    end
    top_r <= top_nxt;
    lo_r <= lo_nxt;
    hie_r <= hie_nxt;
    mid_r <= mid_nxt;
    pos_r <= pos_nxt;
    tline_r <= tline_nxt;
    uline_r <= uline_nxt;
    prod_r <= prod_nxt;
    res_status_r <= res_status_nxt;
    res_value_r <= res_value_nxt;
    if ((state_r == mlh_pkg::S_DONE) && (!out_valid_r || out_ready)) begin
      out_status_r <= res_status_r;
      out_value_r <= res_value_r;
      out_count_r <= size_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_value = out_value_r;
  assign out_line_count = mlh_pkg::COUNT_W'(out_count_r);

  // hull never grows past the store depth
  `MLH_ASSERT_NOW(a_size_bound, 1'b1, size_r <= CW'(mlh_pkg::HULL_DEPTH))
  // a push lands at or below the current size
  `MLH_ASSERT_NOW(a_push_addr, ram_we, top_r <= size_r)
  // a query leaves the hull size alone
  `MLH_ASSERT_NEXT(a_query_keeps, in_take && (in_req_type == mlh_pkg::REQ_QUERY),
    size_r == $past(size_r))
  // adds refused as full never write the line memory
  `MLH_ASSERT_NOW(a_no_write_on_error, ram_we && (kind_r == mlh_pkg::REQ_ADD),
    top_r < CW'(mlh_pkg::HULL_DEPTH))
endmodule
